/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the link quality block.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/lqh_pkg.sv */
// Package for the link quality hysteresis block: sizes, codes and beat types.
// Used by the top level; depends on nothing else.
package lqh_pkg;

    localparam int LINK_COUNT = 256;
    localparam int LINK_AW = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;

    localparam int LINK_W = 8;
    localparam int QUAL_W = 10;
    localparam int TIME_W = 32;
    localparam int RELOAD_W = 33;
    localparam int CFG_INDEX_W = 2;

    localparam logic [QUAL_W-1:0] Q_FULL = 10'd1000;
    localparam int ROUND_UP = 999;

    // Division by 1000 as a multiplication by a scaled reciprocal.
    // Exact for dividends below 2**30 / 176, far above the largest one.
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_MULT = ((1 << RECIP_SHIFT) + 999) / 1000;
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_HELLO = 2'd1;
    localparam logic [1:0] MODE_LOST = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REJECT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALING = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [LINK_W-1:0] link_id;
        logic [TIME_W-1:0] hello_interval;
        logic [TIME_W-1:0] validity_time;
    } in_item_t;

    typedef struct packed {
        logic [LINK_W-1:0]   result_link;
        logic [QUAL_W-1:0]   link_quality;
        logic                link_pending;
        logic                is_lost;
        logic                status_changed;
        logic                reload_valid;
        logic [RELOAD_W-1:0] timer_reload;
    } out_item_t;

    typedef struct packed {
        logic [QUAL_W-1:0] quality;
        logic              pending;
        logic              lost;
        logic [TIME_W-1:0] interval;
    } entry_t;

endpackage

/* rtl/link_quality_hysteresis.sv */
// Link quality hysteresis table: one RAM entry per link, aged by a shared multiplier.
// Hello and lost events step through S_SCALE and S_RECIP, the two passes through the
// single multiplier, to S_FINISH; link-added events go straight to S_FINISH. S_FINISH
// writes back the entry read at acceptance and waits while a result is still held.
// Events are taken only in S_IDLE; those with the unused mode give no result.
// Reset is asynchronous and active low; it clears control state and restores the levels.
module link_quality_hysteresis (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  lqh_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output lqh_pkg::out_item_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lqh_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lqh_pkg::QUAL_W-1:0]          cfg_data
);
    import lqh_pkg::*;

`include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCALE  = 4'b0010,
        S_RECIP  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [QUAL_W-1:0] accept_reg, reject_reg, scaling_reg;
    in_item_t          item_reg;
    logic [MUL_P_W-1:0] mul_reg, mul_next;
    logic              out_valid_reg;
    out_item_t         out_data_reg, out_data_next;

    logic              in_fire, item_ok, index_ok, out_free, finish_fire;
    logic [QUAL_W-1:0] s_sat, q_old, q_new;
    logic [QUAL_W:0]   aged, q_sum;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [TIME_W-1:0] iv;
    logic [TIME_W+1:0] iv_triple;
    logic              was_up, pending_new, lost_new, changed;
    entry_t            ram_rdata, ram_wdata;

    assign index_ok = int'(in_data.link_id) < LINK_COUNT;
    assign item_ok = (in_data.mode != MODE_UNUSED) && index_ok;
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign finish_fire = (state_reg == S_FINISH) && out_free;
    assign cfg_ready = 1'b1;

    lqh_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (LINK_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (finish_fire),
        .waddr (LINK_AW'(item_reg.link_id)),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (LINK_AW'(in_data.link_id)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && item_ok)
                begin
                    state_next = (in_data.mode == MODE_ADD) ? S_FINISH : S_SCALE;
                end
            end
            S_SCALE:  state_next = S_RECIP;
            S_RECIP:  state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // The one multiplier first forms quality times the aging weight, then divides
    // the rounded-up product by 1000 through the reciprocal.
    always_comb
    begin
        s_sat = (scaling_reg > Q_FULL) ? Q_FULL : scaling_reg;
        q_old = (ram_rdata.quality > Q_FULL) ? Q_FULL : ram_rdata.quality;
        unique case (state_reg)
            S_SCALE:
            begin
                mul_a = MUL_A_W'(q_old);
                mul_b = MUL_B_W'(Q_FULL - s_sat);
            end
            S_RECIP:
            begin
                mul_a = mul_reg[MUL_A_W-1:0] + MUL_A_W'(ROUND_UP);
                mul_b = MUL_B_W'(RECIP_MULT);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_next = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    always_comb
    begin
        aged = mul_reg[RECIP_SHIFT +: QUAL_W+1];
        q_sum = aged + ((item_reg.mode == MODE_HELLO) ? {1'b0, s_sat} : '0);
        q_new = (q_sum > {1'b0, Q_FULL}) ? Q_FULL : q_sum[QUAL_W-1:0];

        was_up = !ram_rdata.pending && !ram_rdata.lost;
        pending_new = ram_rdata.pending;
        lost_new = ram_rdata.lost;
        changed = 1'b0;
        if (was_up)
        begin
            if (q_new < reject_reg)
            begin
                lost_new = 1'b1;
                changed = 1'b1;
            end
        end
        else if (q_new > accept_reg)
        begin
            pending_new = 1'b0;
            lost_new = 1'b0;
            changed = 1'b1;
        end

        iv = (item_reg.hello_interval != '0) ? item_reg.hello_interval
                                             : item_reg.validity_time;
        iv_triple = {2'b00, iv} + {1'b0, iv, 1'b0};

        out_data_next.result_link = item_reg.link_id;
        unique case (item_reg.mode)
            MODE_HELLO:
            begin
                ram_wdata = '{quality: q_new, pending: pending_new, lost: lost_new,
                              interval: iv};
                out_data_next.link_quality = q_new;
                out_data_next.link_pending = pending_new;
                out_data_next.is_lost = lost_new;
                out_data_next.status_changed = changed;
                out_data_next.reload_valid = 1'b1;
                out_data_next.timer_reload = iv_triple[TIME_W+1:1];
            end
            MODE_LOST:
            begin
                ram_wdata = '{quality: q_new, pending: pending_new, lost: lost_new,
                              interval: ram_rdata.interval};
                out_data_next.link_quality = q_new;
                out_data_next.link_pending = pending_new;
                out_data_next.is_lost = lost_new;
                out_data_next.status_changed = changed;
                out_data_next.reload_valid = 1'b1;
                out_data_next.timer_reload = RELOAD_W'(ram_rdata.interval);
            end
            default:
            begin
                ram_wdata = '{quality: '0, pending: 1'b1, lost: 1'b0, interval: '0};
                out_data_next.link_quality = '0;
                out_data_next.link_pending = 1'b1;
                out_data_next.is_lost = 1'b0;
                out_data_next.status_changed = 1'b0;
                out_data_next.reload_valid = 1'b0;
                out_data_next.timer_reload = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            accept_reg <= 10'd700;
            reject_reg <= 10'd300;
            scaling_reg <= 10'd250;
        end
        else
        begin
            state_reg <= state_next;
            if (finish_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_ACCEPT:  accept_reg <= cfg_data;
                    CFG_REJECT:  reject_reg <= cfg_data;
                    CFG_SCALING: scaling_reg <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
        if ((state_reg == S_SCALE) || (state_reg == S_RECIP))
        begin
            mul_reg <= mul_next;
        end
        if (finish_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    `ASSERT_CLK(a_busy_after_accept, in_fire && item_ok |=> !in_ready, "block ready while busy")
    `ASSERT_CLK(a_result_from_finish, $rose(out_valid_reg) |-> $past(state_reg == S_FINISH), "result without update")
    `ASSERT_NEVER(a_quality_range, out_valid_reg && (out_data_reg.link_quality > Q_FULL), "quality out of range")
    `ASSERT_NEVER(a_reload_zero, out_valid_reg && !out_data_reg.reload_valid && (out_data_reg.timer_reload != '0), "reload set without valid")

endmodule

/* rtl/lqh_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; holds the link table entries for the top level.
module lqh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
